// ===== design/ciwx_pkg.sv =====
package ciwx_pkg;

  // Key table geometry
  localparam int TABLE_SIZE = 512;
  localparam int HALF_SIZE  = TABLE_SIZE / 2;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int IDX_W      = $clog2(HALF_SIZE);

  localparam logic [7:0] OUT_MASK = 8'hAB;

  // APB register indexes
  localparam logic REG_P_SEED = 1'b0;
  localparam logic REG_G_SEED = 1'b1;

  typedef enum logic [1:0] {
    OP_GEN = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_MIX,
    ST_DONE,
    ST_GEN
  } st_t;

  typedef enum logic [2:0] {
    KG_IDLE,
    KG_P1,
    KG_P2,
    KG_G1,
    KG_G2
  } kg_st_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } kg_wr_t;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

endpackage

// ===== design/ciwx_mac.sv =====
module ciwx_mac (
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  input  logic       sub,
  output logic [7:0] y
);

  logic [15:0] prod;

  // Everything is mod 256: keep the low byte of the product
  assign prod = a * b;
  assign y    = sub ? (c - prod[7:0]) : (c + prod[7:0]);

endmodule

// ===== design/ciwx_key_ram.sv =====
module ciwx_key_ram (
  input  logic                    clk,
  input  ciwx_pkg::kg_wr_t        wr,
  input  logic [ciwx_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]              rdata
);

  import ciwx_pkg::*;

  logic [7:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ciwx_keygen.sv =====
module ciwx_keygen (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      p_seed,
  input  logic [31:0]      g_seed,
  output ciwx_pkg::kg_wr_t wr,
  output logic             done
);

  import ciwx_pkg::*;

  kg_st_t           st;
  kg_st_t           st_next;
  logic [31:0]      ps;
  logic [31:0]      gs;
  logic [7:0]       px;
  logic [7:0]       gx;
  logic [7:0]       t;
  logic [IDX_W-1:0] idx;
  logic [7:0]       mac_a;
  logic [7:0]       mac_b;
  logic [7:0]       mac_c;
  logic             mac_sub;
  logic [7:0]       mac_y;

  // One multiply-add shared by both halves and both steps of the recurrence
  ciwx_mac u_mac (
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .sub (mac_sub),
    .y   (mac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= KG_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    mac_a   = px;
    mac_b   = ps[23:16];
    mac_c   = ps[15:8];
    mac_sub = 1'b0;
    wr.en   = 1'b0;
    wr.addr = {1'b0, idx};
    wr.data = px;
    done    = 1'b0;
    case (st)
      KG_IDLE: begin
        if (start) begin
          st_next = KG_P1;
        end
      end
      KG_P1: begin
        wr.en   = 1'b1;
        st_next = KG_P2;
      end
      KG_P2: begin
        mac_b   = t;
        mac_c   = ps[31:24];
        st_next = KG_G1;
      end
      KG_G1: begin
        mac_a   = gx;
        mac_b   = gs[23:16];
        mac_c   = gs[15:8];
        mac_sub = 1'b1;
        wr.en   = 1'b1;
        wr.addr = {1'b1, idx};
        wr.data = gx;
        st_next = KG_G2;
      end
      KG_G2: begin
        mac_a = gx;
        mac_b = t;
        mac_c = gs[31:24];
        if (idx == {IDX_W{1'b1}}) begin
          done    = 1'b1;
          st_next = KG_IDLE;
        end else begin
          st_next = KG_P1;
        end
      end
      default: begin
        st_next = KG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      KG_IDLE: begin
        if (start) begin
          ps  <= p_seed;
          gs  <= g_seed;
          px  <= p_seed[7:0];
          gx  <= g_seed[7:0];
          idx <= '0;
        end
      end
      KG_P1:   t  <= mac_y;
      KG_P2:   px <= mac_y;
      KG_G1:   t  <= mac_y;
      KG_G2: begin
        gx  <= mac_y;
        idx <= idx + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/counter_indexed_xor_stream_cipher.sv =====
// Encrypt/decrypt beat: with a key table ST_RD_LO, ST_RD_HI, ST_MIX, then ST_DONE,
// set by the two reads through the single table read port; without, only ST_DONE.
// A new beat is taken once back in ST_IDLE; ST_DONE holds while the output stalls.
// Generate beat: 256 indexes, each via KG_P1, KG_P2, KG_G1 and KG_G2 on the shared
// multiply-add, no output beat; input reopens on kg_done. Counter reset: in ST_IDLE.
// Synchronous active-high reset clears counters, table flag, seeds and handshake state.
module counter_indexed_xor_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_in
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        s_tlast,   // last_in
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data_out
  output logic        m_tlast,   // last_out
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ciwx_pkg::*;

  st_t               st;
  st_t               st_next;
  logic [31:0]       p_seed;
  logic [31:0]       g_seed;
  logic              table_ready;
  logic [15:0]       encrypt_count;
  logic [15:0]       decrypt_count;
  logic [15:0]       cnt_sel;
  logic              is_enc;
  logic [7:0]        work;
  logic              work_last;
  logic [7:0]        mix;
  logic [7:0]        result;
  logic              in_beat;
  logic              out_load;
  op_t               op;
  logic              kg_start;
  logic              kg_done;
  kg_wr_t            kg_wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign op      = op_t'(s_tuser);
  assign in_beat = s_tvalid && s_tready;

  // APB: always ready, write lands on the access cycle
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_G_SEED) ? g_seed : p_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_seed <= '0;
      g_seed <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_P_SEED) begin
        p_seed <= pwdata;
      end else begin
        g_seed <= pwdata;
      end
    end
  end

  ciwx_keygen u_keygen (
    .clk    (clk),
    .rst    (rst),
    .start  (kg_start),
    .p_seed (p_seed),
    .g_seed (g_seed),
    .wr     (kg_wr),
    .done   (kg_done)
  );

  ciwx_key_ram u_key_ram (
    .clk   (clk),
    .wr    (kg_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Finish the byte: table mix is zero when no table exists
  assign result = is_enc ? (swap_nibbles(work ^ mix) ^ OUT_MASK)
                         : (swap_nibbles(work ^ OUT_MASK) ^ mix);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Sequencer: one beat in flight; the output register lets the next beat in early
  always_comb begin
    st_next  = st;
    s_tready = 1'b0;
    kg_start = 1'b0;
    out_load = 1'b0;
    raddr    = {1'b0, cnt_sel[7:0]};
    case (st)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (op)
            OP_GEN: begin
              kg_start = 1'b1;
              st_next  = ST_GEN;
            end
            OP_ENC, OP_DEC: begin
              st_next = table_ready ? ST_RD_LO : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_RD_LO: begin
        st_next = ST_RD_HI;
      end
      ST_RD_HI: begin
        raddr   = {1'b1, cnt_sel[15:8]};
        st_next = ST_MIX;
      end
      ST_MIX: begin
        st_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      ST_GEN: begin
        if (kg_done) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // Counters and table flag
  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_count <= '0;
      decrypt_count <= '0;
      table_ready   <= 1'b0;
    end else begin
      if (kg_done) begin
        table_ready <= 1'b1;
      end
      if (in_beat) begin
        case (op)
          OP_ENC: encrypt_count <= encrypt_count + 1'b1;
          OP_DEC: decrypt_count <= decrypt_count + 1'b1;
          OP_CLR: begin
            encrypt_count <= '0;
            decrypt_count <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Working byte, counter snapshot and table mix
  always_ff @(posedge clk) begin
    if (in_beat) begin
      work      <= s_tdata;
      work_last <= s_tlast;
      is_enc    <= (op == OP_ENC);
      cnt_sel   <= (op == OP_ENC) ? encrypt_count : decrypt_count;
      mix       <= '0;
    end else if (st == ST_RD_HI) begin
      mix <= rdata;
    end else if (st == ST_MIX) begin
      mix <= mix ^ rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
      m_tlast <= work_last;
    end
  end

endmodule
